>>> design/oasht_pkg.sv
`timescale 1ns / 1ps
package oasht_pkg;

    localparam int SLOTS     = 1024;
    localparam int KEY_CHARS = 7;

    localparam int ADDR_W  = $clog2(SLOTS);
    localparam int SIZE_W  = $clog2(SLOTS) + 1;
    localparam int KEY_W   = 8 * KEY_CHARS;
    localparam int LEN_W   = 3;
    localparam int VAL_W   = 31;
    localparam int TSIZE_W = 11;
    localparam int IDX_W   = 10;
    localparam int HASH_W  = 64;
    localparam int DIV_CW  = $clog2(HASH_W);

    localparam logic [HASH_W-1:0] FNV_BASIS = 64'd14695981039346656037;
    localparam logic [HASH_W-1:0] MOD_CONST = 64'd61;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_DUPLICATE = 2'd1;
    localparam logic [1:0] ST_LIMIT     = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    localparam logic [1:0] CFG_HASH_SELECT = 2'd0;
    localparam logic [1:0] CFG_PROBE_MODE  = 2'd1;
    localparam logic [1:0] CFG_TABLE_SIZE  = 2'd2;

    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [LEN_W-1:0]  len;
        logic [VAL_W-1:0]  value;
    } t_entry;

    typedef struct packed {
        logic clear_wr;
        logic load;
        logic hash_step;
        logic hash_final;
        logic div_step;
        logic setup_step;
        logic walk_init;
        logic check;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic op_none;
        logic clear_done;
        logic chars_done;
        logic div_done;
        logic setup_done;
        logic walk_stop;
    } t_stat;

endpackage

>>> design/oasht_ram.sv
`timescale 1ns / 1ps
module oasht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/oasht_datapath.sv
`timescale 1ns / 1ps
module oasht_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  oasht_pkg::t_cmd                i_cmd,
    output oasht_pkg::t_stat               o_stat,
    input  logic                           i_cfg_we,
    input  logic [1:0]                     i_cfg_index,
    input  logic [oasht_pkg::TSIZE_W-1:0]  i_cfg_data,
    input  logic [1:0]                     i_operation,
    input  logic [oasht_pkg::KEY_W-1:0]    i_key_chars,
    input  logic [oasht_pkg::LEN_W-1:0]    i_key_length,
    input  logic [oasht_pkg::VAL_W-1:0]    i_entry_value,
    output logic [1:0]                     o_status,
    output logic [oasht_pkg::VAL_W-1:0]    o_found_value,
    output logic [oasht_pkg::IDX_W-1:0]    o_slot_index
);

    localparam int SW = oasht_pkg::SIZE_W;
    localparam int HW = oasht_pkg::HASH_W;

    // configuration
    logic                          r_hash_select;
    logic                          r_probe_mode;
    logic [oasht_pkg::TSIZE_W-1:0] r_table_size;

    // request
    logic [1:0]                    r_op;
    logic [oasht_pkg::KEY_W-1:0]   r_key;
    logic [oasht_pkg::KEY_W-1:0]   r_key_shift;
    logic [oasht_pkg::LEN_W-1:0]   r_len;
    logic [oasht_pkg::VAL_W-1:0]   r_value;
    logic [SW-1:0]                 r_size;
    logic [oasht_pkg::LEN_W-1:0]   r_char_cnt;

    // hashing and reduction
    logic [HW-1:0]                 r_h_prim;
    logic [HW-1:0]                 r_h_aux;
    logic [HW-1:0]                 r_dv_home;
    logic [HW-1:0]                 r_dv_aux;
    logic [HW-1:0]                 r_dv_c61;
    logic [SW-1:0]                 r_rm_home;
    logic [SW-1:0]                 r_rm_aux;
    logic [SW-1:0]                 r_rm_c61;
    logic [oasht_pkg::DIV_CW-1:0]  r_div_cnt;
    logic [2:0]                    r_setup_cnt;
    logic [SW-1:0]                 r_c7;

    // walk
    logic [SW-1:0]                 r_pos;
    logic [SW-1:0]                 r_inc;
    logic [SW-1:0]                 r_c122;
    logic [SW-1:0]                 r_k;
    logic [1:0]                    r_status;
    logic [oasht_pkg::VAL_W-1:0]   r_found;
    logic [oasht_pkg::ADDR_W-1:0]  r_clr_cnt;

    // result
    logic [1:0]                    r_out_status;
    logic [oasht_pkg::VAL_W-1:0]   r_out_found;
    logic [oasht_pkg::IDX_W-1:0]   r_out_index;

    logic [oasht_pkg::KEY_W-1:0]   n_key;
    logic [SW-1:0]                 n_size;
    logic [31:0]                   w_tsize;
    logic [7:0]                    w_char;
    logic [HW-1:0]                 w_prim_next;
    logic [HW-1:0]                 w_aux_next;
    logic [HW-1:0]                 w_aux_final;
    logic [HW-1:0]                 w_t0;
    logic [HW-1:0]                 w_t1;
    logic [HW-1:0]                 w_f0;
    logic [HW-1:0]                 w_f1;
    oasht_pkg::t_entry             w_rd;
    oasht_pkg::t_entry             w_wdata;
    logic                          w_we;
    logic [oasht_pkg::ADDR_W-1:0]  w_waddr;
    logic                          w_match;
    logic                          w_limit;
    logic [SW-1:0]                 w_k_next;

    function automatic logic [SW-1:0] add_mod(input logic [SW-1:0] a,
                                              input logic [SW-1:0] b,
                                              input logic [SW-1:0] m);
        logic [SW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[SW-1:0];
    endfunction

    // one restoring step of the remainder
    function automatic logic [SW-1:0] rem_step(input logic [SW-1:0] r,
                                               input logic          b,
                                               input logic [SW-1:0] m);
        logic [SW:0] t;
        t = {r, b};
        if (t >= {1'b0, m}) begin
            t = t - {1'b0, m};
        end
        return t[SW-1:0];
    endfunction

    always_comb begin
        n_key = '0;
        for (int i = 0; i < oasht_pkg::KEY_CHARS; i++) begin
            if (i < int'(i_key_length)) begin
                n_key[8*i +: 8] = i_key_chars[8*i +: 8];
            end
        end
    end

    assign w_tsize = 32'(r_table_size);
    always_comb begin
        if (w_tsize < 32'd2) begin
            n_size = SW'(2);
        end else if (w_tsize > 32'(oasht_pkg::SLOTS)) begin
            n_size = SW'(oasht_pkg::SLOTS);
        end else begin
            n_size = SW'(w_tsize);
        end
    end

    assign w_char = r_key_shift[7:0];

    always_comb begin
        if (r_hash_select) begin
            // prime = 2^40 + 435
            w_prim_next = ((r_h_prim << 40) + (r_h_prim << 8) + (r_h_prim << 7)
                         + (r_h_prim << 5) + (r_h_prim << 4) + (r_h_prim << 1)
                         + r_h_prim) ^ HW'(w_char);
        end else begin
            w_prim_next = (r_h_prim << 5) + (r_h_prim << 1) + HW'(w_char);
        end
    end

    assign w_t0        = r_h_aux + HW'(w_char);
    assign w_t1        = w_t0 + (w_t0 << 10);
    assign w_aux_next  = w_t1 ^ (w_t1 >> 6);
    assign w_f0        = r_h_aux + (r_h_aux << 3);
    assign w_f1        = w_f0 ^ (w_f0 >> 11);
    assign w_aux_final = w_f1 + (w_f1 << 15);

    assign w_match  = w_rd.valid && (w_rd.len == r_len) && (w_rd.key == r_key);
    assign w_k_next = r_k + SW'(1);
    assign w_limit  = (w_k_next == r_size);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_pos[oasht_pkg::ADDR_W-1:0];
        w_wdata = '0;
        if (i_cmd.clear_wr) begin
            w_we    = 1'b1;
            w_waddr = r_clr_cnt;
        end else if (i_cmd.check) begin
            if (!w_rd.valid && r_op == oasht_pkg::OP_INSERT) begin
                w_we          = 1'b1;
                w_wdata.valid = 1'b1;
                w_wdata.key   = r_key;
                w_wdata.len   = r_len;
                w_wdata.value = r_value;
            end else if (w_match && r_op == oasht_pkg::OP_DELETE) begin
                w_we = 1'b1;
            end
        end
    end

    oasht_ram #(
        .WIDTH($bits(oasht_pkg::t_entry)),
        .DEPTH(oasht_pkg::SLOTS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(r_pos[oasht_pkg::ADDR_W-1:0]),
        .o_rdata(w_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash_select <= 1'b0;
            r_probe_mode  <= 1'b0;
            r_table_size  <= oasht_pkg::TSIZE_W'(1024);
            r_clr_cnt     <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    oasht_pkg::CFG_HASH_SELECT: r_hash_select <= i_cfg_data[0];
                    oasht_pkg::CFG_PROBE_MODE:  r_probe_mode  <= i_cfg_data[0];
                    oasht_pkg::CFG_TABLE_SIZE:  r_table_size  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.clear_wr) begin
                r_clr_cnt <= r_clr_cnt + oasht_pkg::ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op        <= i_operation;
            r_key       <= n_key;
            r_key_shift <= n_key;
            r_len       <= i_key_length;
            r_value     <= i_entry_value;
            r_size      <= n_size;
            r_char_cnt  <= '0;
            r_h_prim    <= r_hash_select ? oasht_pkg::FNV_BASIS : '0;
            r_h_aux     <= '0;
            r_status    <= oasht_pkg::ST_NOT_FOUND;
            r_found     <= '0;
            r_pos       <= '0;
        end
        if (i_cmd.hash_step) begin
            r_h_prim    <= w_prim_next;
            r_h_aux     <= w_aux_next;
            r_key_shift <= r_key_shift >> 8;
            r_char_cnt  <= r_char_cnt + oasht_pkg::LEN_W'(1);
        end
        if (i_cmd.hash_final) begin
            r_dv_home <= r_h_prim;
            r_dv_aux  <= w_aux_final;
            r_dv_c61  <= oasht_pkg::MOD_CONST;
            r_rm_home <= '0;
            r_rm_aux  <= '0;
            r_rm_c61  <= '0;
            r_div_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_rm_home <= rem_step(r_rm_home, r_dv_home[HW-1], r_size);
            r_rm_aux  <= rem_step(r_rm_aux,  r_dv_aux[HW-1],  r_size);
            r_rm_c61  <= rem_step(r_rm_c61,  r_dv_c61[HW-1],  r_size);
            r_dv_home <= r_dv_home << 1;
            r_dv_aux  <= r_dv_aux << 1;
            r_dv_c61  <= r_dv_c61 << 1;
            r_div_cnt <= r_div_cnt + oasht_pkg::DIV_CW'(1);
            r_setup_cnt <= '0;
            r_c7        <= '0;
        end
        if (i_cmd.setup_step) begin
            // seven times the step, reduced
            r_c7        <= add_mod(r_c7, r_rm_aux, r_size);
            r_setup_cnt <= r_setup_cnt + 3'd1;
        end
        if (i_cmd.walk_init) begin
            r_pos  <= r_rm_home;
            r_k    <= SW'(1);
            r_c122 <= add_mod(r_rm_c61, r_rm_c61, r_size);
            r_inc  <= r_probe_mode ? add_mod(r_c7, r_rm_c61, r_size) : r_rm_aux;
        end
        if (i_cmd.check) begin
            if (!w_rd.valid) begin
                r_status <= (r_op == oasht_pkg::OP_INSERT) ? oasht_pkg::ST_DONE
                                                           : oasht_pkg::ST_NOT_FOUND;
            end else if (w_match) begin
                if (r_op == oasht_pkg::OP_INSERT) begin
                    r_status <= oasht_pkg::ST_DUPLICATE;
                end else begin
                    r_status <= oasht_pkg::ST_DONE;
                    if (r_op == oasht_pkg::OP_SEARCH) begin
                        r_found <= w_rd.value;
                    end
                end
            end else begin
                // second difference of the quadratic probe is 122
                r_pos <= add_mod(r_pos, r_inc, r_size);
                if (r_probe_mode) begin
                    r_inc <= add_mod(r_inc, r_c122, r_size);
                end
                r_k <= w_k_next;
                if (w_limit) begin
                    r_status <= oasht_pkg::ST_LIMIT;
                end
            end
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_status;
            r_out_found  <= r_found;
            r_out_index  <= oasht_pkg::IDX_W'(r_pos);
        end
    end

    assign o_stat.op_none    = (i_operation == oasht_pkg::OP_NONE);
    assign o_stat.clear_done = (r_clr_cnt == oasht_pkg::ADDR_W'(oasht_pkg::SLOTS - 1));
    assign o_stat.chars_done = (r_char_cnt == r_len);
    assign o_stat.div_done   = (r_div_cnt == oasht_pkg::DIV_CW'(HW - 1));
    assign o_stat.setup_done = (r_setup_cnt == 3'd7);
    assign o_stat.walk_stop  = !w_rd.valid || w_match || w_limit;

    assign o_status      = r_out_status;
    assign o_found_value = r_out_found;
    assign o_slot_index  = r_out_index;

endmodule

>>> design/oasht_ctrl.sv
`timescale 1ns / 1ps
module oasht_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    input  oasht_pkg::t_stat  i_stat,
    output oasht_pkg::t_cmd   o_cmd
);

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_HASH   = 9'b000000100,
        S_FINAL  = 9'b000001000,
        S_DIVIDE = 9'b000010000,
        S_SETUP  = 9'b000100000,
        S_READ   = 9'b001000000,
        S_CHECK  = 9'b010000000,
        S_FINISH = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_stat.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_stat.op_none ? S_FINISH : S_HASH;
                end
            end
            S_HASH: begin
                if (i_stat.chars_done) begin
                    n_state = S_FINAL;
                end else begin
                    o_cmd.hash_step = 1'b1;
                end
            end
            S_FINAL: begin
                o_cmd.hash_final = 1'b1;
                n_state          = S_DIVIDE;
            end
            S_DIVIDE: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_done) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                if (i_stat.setup_done) begin
                    o_cmd.walk_init = 1'b1;
                    n_state         = S_READ;
                end else begin
                    o_cmd.setup_step = 1'b1;
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = i_stat.walk_stop ? S_FINISH : S_READ;
            end
            S_FINISH: begin
                if (!r_out_valid || i_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;

endmodule

>>> design/open_address_string_hash_table.sv
`timescale 1ns / 1ps
// channel   valid        ready        payload
// request   i_valid      o_ready      i_operation i_key_chars i_key_length i_entry_value
// result    o_valid      i_ready      o_status o_found_value o_slot_index
// config    i_cfg_valid  o_cfg_ready  i_cfg_index i_cfg_data
//
// a request is loaded, hashed one character per cycle and finalised; the remainders are
// found bit-serially, the probe step is set up, and each probe reads then checks a slot;
// the result is then loaded. operation code three goes straight to the result.
// after reset a clearing pass empties all 1024 slots of the memory; no request is taken.
// a finished result waits in the output register while the next request is taken; the last
// cycle of that request repeats until the waiting result is accepted.
module open_address_string_hash_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_operation,
    input  logic [oasht_pkg::KEY_W-1:0]   i_key_chars,
    input  logic [oasht_pkg::LEN_W-1:0]   i_key_length,
    input  logic [oasht_pkg::VAL_W-1:0]   i_entry_value,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [1:0]                    o_status,
    output logic [oasht_pkg::VAL_W-1:0]   o_found_value,
    output logic [oasht_pkg::IDX_W-1:0]   o_slot_index,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [oasht_pkg::TSIZE_W-1:0] i_cfg_data
);

    oasht_pkg::t_cmd  w_cmd;
    oasht_pkg::t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    oasht_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .i_stat (w_stat),
        .o_cmd  (w_cmd)
    );

    oasht_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_operation  (i_operation),
        .i_key_chars  (i_key_chars),
        .i_key_length (i_key_length),
        .i_entry_value(i_entry_value),
        .o_status     (o_status),
        .o_found_value(o_found_value),
        .o_slot_index (o_slot_index)
    );

endmodule
